[hdl/i2cms_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cms_pkg;

    localparam int CFG_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIT_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_TICKS  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACK_TIMEOUT = 2'd3;

    localparam logic [CFG_WIDTH-1:0] SHORT_TICKS_RESET = 8'd1;
    localparam logic [CFG_WIDTH-1:0] BIT_TICKS_RESET   = 8'd2;
    localparam logic [CFG_WIDTH-1:0] EDGE_TICKS_RESET  = 8'd4;
    localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_RECEIVED = 2'd1;
    localparam logic [1:0] ACK_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_ACK      = 3'd5,
        CMD_NACK     = 3'd6,
        CMD_READ_ACK = 3'd7
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S_A  = 5'd1,
        PH_S_B  = 5'd2,
        PH_P_A  = 5'd3,
        PH_P_B  = 5'd4,
        PH_T_A  = 5'd5,
        PH_T_B  = 5'd6,
        PH_W_A  = 5'd7,
        PH_W_B  = 5'd8,
        PH_W_C  = 5'd9,
        PH_R_A  = 5'd10,
        PH_R_B  = 5'd11,
        PH_K_A  = 5'd12,
        PH_K_B  = 5'd13,
        PH_Q_A  = 5'd14,
        PH_Q_B  = 5'd15,
        PH_Q_P  = 5'd16
    } phase_t;

    // One tick as it travels from the front queue to the sequencer.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] wr_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_ticks;
        logic [CFG_WIDTH-1:0] bit_ticks;
        logic [CFG_WIDTH-1:0] edge_ticks;
        logic [CFG_WIDTH-1:0] ack_timeout;
    } cfg_t;

endpackage
`default_nettype wire

[hdl/i2cms_front.sv]
// Input side: decodes the command and queues ticks in a two-entry FIFO.
`timescale 1ns / 1ps
`default_nettype none
module i2cms_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_cmd,
    input  wire logic [7:0]           s_wr_byte,
    input  wire logic                 s_sda_in,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output i2cms_pkg::item_t          q_item
);
    import i2cms_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    item_t      in_item;

    always_comb begin
        in_item.cmd     = cmd_t'(s_cmd);
        in_item.wr_byte = s_wr_byte;
        in_item.sda_in  = s_sda_in;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

[hdl/i2cms_engine.sv]
// Back end: the bus phase sequencer, advancing one tick per transaction.
`timescale 1ns / 1ps
`default_nettype none
module i2cms_engine #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire i2cms_pkg::cfg_t      cfg,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire i2cms_pkg::item_t     q_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_scl,
    output logic                      m_sda_out,
    output logic                      m_sda_drive,
    output logic                      m_busy_res,
    output logic                      m_done_res,
    output logic [7:0]                m_rd_byte,
    output logic [1:0]                m_ack_status
);
    import i2cms_pkg::*;

    localparam int WIDE = 17;
    localparam logic [WIDE-1:0] CMAX = (WIDE'(1) << COUNT_WIDTH) - WIDE'(1);

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]             bit_index_reg, bit_index_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             poll_reg, poll_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   drv_reg, drv_next;
    logic [7:0]             rd_reg, rd_next;
    logic [1:0]             ack_reg, ack_next;
    logic                   done_reg, done_next;
    logic                   valid_reg;
    logic                   step;
    logic [3:0]             bit_inc;

    // Phase length minus one; a zero setting acts as one, and long settings saturate.
    function automatic logic [COUNT_WIDTH-1:0] to_count(input logic [CFG_WIDTH-1:0] dur);
        logic [CFG_WIDTH-1:0] d;
        logic [WIDE-1:0]      dw;
        d  = (dur == '0) ? '0 : dur - CFG_WIDTH'(1);
        dw = WIDE'(d);
        if (dw > CMAX) begin
            return CMAX[COUNT_WIDTH-1:0];
        end
        return dw[COUNT_WIDTH-1:0];
    endfunction

    assign q_ready = !valid_reg || m_ready;
    assign step    = q_valid && q_ready;
    assign bit_inc = bit_index_reg + 4'd1;

    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drv_next       = drv_reg;
        rd_next        = rd_reg;
        ack_next       = ack_reg;
        done_next      = 1'b0;

        if (phase_reg == PH_IDLE) begin
            case (q_item.cmd)
                CMD_START: begin
                    {scl_next, sda_next, drv_next} = 3'b111;
                    phase_next = PH_S_A;
                    tick_next  = to_count(cfg.edge_ticks);
                end
                CMD_STOP: begin
                    {scl_next, sda_next, drv_next} = 3'b001;
                    phase_next = PH_P_A;
                    tick_next  = to_count(cfg.edge_ticks);
                end
                CMD_WRITE: begin
                    scl_next       = 1'b0;
                    sda_next       = q_item.wr_byte[7];
                    drv_next       = 1'b1;
                    shift_next     = {q_item.wr_byte[6:0], 1'b0};
                    bit_index_next = 4'd0;
                    phase_next     = PH_W_A;
                    tick_next      = to_count(cfg.bit_ticks);
                end
                CMD_READ: begin
                    {scl_next, sda_next, drv_next} = 3'b010;
                    shift_next     = 8'd0;
                    bit_index_next = 4'd0;
                    phase_next     = PH_R_A;
                    tick_next      = to_count(cfg.bit_ticks);
                end
                CMD_ACK: begin
                    {scl_next, sda_next, drv_next} = 3'b001;
                    phase_next = PH_K_A;
                    tick_next  = to_count(cfg.bit_ticks);
                end
                CMD_NACK: begin
                    {scl_next, sda_next, drv_next} = 3'b011;
                    phase_next = PH_K_A;
                    tick_next  = to_count(cfg.bit_ticks);
                end
                CMD_READ_ACK: begin
                    ack_next   = ACK_NONE;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    phase_next = PH_Q_A;
                    tick_next  = to_count(cfg.short_ticks);
                end
                default: begin
                end
            endcase
        end else if (tick_reg != '0) begin
            tick_next = tick_reg - COUNT_WIDTH'(1);
        end else begin
            case (phase_reg)
                PH_S_A: begin
                    sda_next   = 1'b0;
                    phase_next = PH_S_B;
                    tick_next  = to_count(cfg.edge_ticks);
                end
                PH_S_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_P_A, PH_T_A: begin
                    {scl_next, sda_next, drv_next} = 3'b111;
                    phase_next = (phase_reg == PH_P_A) ? PH_P_B : PH_T_B;
                    tick_next  = to_count(cfg.edge_ticks);
                end
                PH_P_B: begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_T_B: begin
                    ack_next   = ACK_TIMEOUT;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_W_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_W_B;
                    tick_next  = to_count(cfg.bit_ticks);
                end
                PH_W_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_W_C;
                    tick_next  = to_count(cfg.bit_ticks);
                end
                PH_W_C: begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_W_A;
                        tick_next  = to_count(cfg.bit_ticks);
                    end
                end
                PH_R_A: begin
                    // SDA is captured on the tick that SCL rises.
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[6:0], q_item.sda_in};
                    phase_next = PH_R_B;
                    tick_next  = to_count(cfg.short_ticks);
                end
                PH_R_B: begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        rd_next    = shift_reg;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        scl_next   = 1'b0;
                        phase_next = PH_R_A;
                        tick_next  = to_count(cfg.bit_ticks);
                    end
                end
                PH_K_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_K_B;
                    tick_next  = to_count(cfg.bit_ticks);
                end
                PH_K_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_Q_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_Q_B;
                    tick_next  = to_count(cfg.short_ticks);
                end
                PH_Q_B: begin
                    poll_next  = 8'd0;
                    phase_next = PH_Q_P;
                    tick_next  = '0;
                end
                PH_Q_P: begin
                    if (!q_item.sda_in) begin
                        scl_next   = 1'b0;
                        ack_next   = ACK_RECEIVED;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end else if (poll_reg >= cfg.ack_timeout) begin
                        // No acknowledge in time: release the bus with a stop sequence.
                        {scl_next, sda_next, drv_next} = 3'b001;
                        phase_next = PH_T_A;
                        tick_next  = to_count(cfg.edge_ticks);
                    end else begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // The sequencer state itself serves as the output register: it only moves on a step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_index_reg <= 4'd0;
            shift_reg     <= 8'd0;
            poll_reg      <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b1;
            rd_reg        <= 8'd0;
            ack_reg       <= ACK_NONE;
            done_reg      <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (step) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                poll_reg      <= poll_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                drv_reg       <= drv_next;
                rd_reg        <= rd_next;
                ack_reg       <= ack_next;
                done_reg      <= done_next;
            end
            if (q_ready) begin
                valid_reg <= q_valid;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_scl        = scl_reg;
    assign m_sda_out    = sda_reg;
    assign m_sda_drive  = drv_reg;
    assign m_busy_res   = (phase_reg != PH_IDLE);
    assign m_done_res   = done_reg;
    assign m_rd_byte    = rd_reg;
    assign m_ack_status = ack_reg;

endmodule
`default_nettype wire

[hdl/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: configuration registers, queue and sequencer.
//
// Each input transaction is one timing tick and yields exactly one result transaction with
// the SCL/SDA levels after that tick, the busy and done flags, the last read byte and the
// acknowledge status. The block takes one tick per clock cycle when the result side keeps
// up; each accepted tick is first stored in the two-entry input queue, and the sequencer
// step then loads the state registers, which are the output register.
// Commands are taken only while the sequencer is idle; each bus phase lasts the configured
// number of ticks (a setting of zero acts as one, and settings beyond COUNT_WIDTH saturate).
// The user must write configuration through cfg_wr_en, cfg_index and cfg_wr_data only
// while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_sequencer #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [i2cms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [i2cms_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_cmd,
    input  wire logic [7:0]                        s_wr_byte,
    input  wire logic                              s_sda_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_scl,
    output logic                                   m_sda_out,
    output logic                                   m_sda_drive,
    output logic                                   m_busy_res,
    output logic                                   m_done_res,
    output logic [7:0]                             m_rd_byte,
    output logic [1:0]                             m_ack_status
);
    import i2cms_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid, q_ready;
    item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks <= SHORT_TICKS_RESET;
            cfg_reg.bit_ticks   <= BIT_TICKS_RESET;
            cfg_reg.edge_ticks  <= EDGE_TICKS_RESET;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHORT_TICKS: cfg_reg.short_ticks <= cfg_wr_data;
                REG_BIT_TICKS:   cfg_reg.bit_ticks   <= cfg_wr_data;
                REG_EDGE_TICKS:  cfg_reg.edge_ticks  <= cfg_wr_data;
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    i2cms_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_wr_byte (s_wr_byte),
        .s_sda_in  (s_sda_in),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    i2cms_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl        (m_scl),
        .m_sda_out    (m_sda_out),
        .m_sda_drive  (m_sda_drive),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_rd_byte    (m_rd_byte),
        .m_ack_status (m_ack_status)
    );

endmodule
`default_nettype wire
